FILE: rtl/core/csr_sparse_matvec_defines.svh
// Assertion macros for the sparse matrix-vector block.
// Each expects signals named clock and reset in the enclosing module.
`ifndef CSR_SPARSE_MATVEC_DEFINES_SVH
`define CSR_SPARSE_MATVEC_DEFINES_SVH

// same-cycle implication
`define CSM_ASSERT_IMPLIES(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("csr_sparse_matvec: assertion failed");

// next-cycle implication
`define CSM_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("csr_sparse_matvec: assertion failed");

`endif

FILE: rtl/core/csm_pkg.sv
package csm_pkg;

   localparam int ROWS_MAX_DEF = 64;
   localparam int COLS_MAX_DEF = 64;
   localparam int NNZ_MAX_DEF  = 4096;

   localparam int VEC_DEPTH  = 64;
   localparam int VEC_AW     = 6;
   localparam int COL_W      = 6;
   localparam int CFG_DIM_W  = 7;
   localparam int THR_W      = 31;
   localparam int VALUE_W    = 32;
   localparam int ACC_W      = 64;
   localparam int ROW_IDX_W  = 6;
   localparam int ACTION_W   = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;

   typedef logic [ACTION_W-1:0] action_type;
   localparam action_type ACT_LOAD    = 2'd0;
   localparam action_type ACT_VEC     = 2'd1;
   localparam action_type ACT_COMPUTE = 2'd2;

   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type STAT_OK      = 2'd0;
   localparam status_type STAT_SAT     = 2'd1;
   localparam status_type STAT_IGNORED = 2'd2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_NUM_ROWS  = 2'd0;
   localparam csr_idx_type CSR_NUM_COLS  = 2'd1;
   localparam csr_idx_type CSR_THRESHOLD = 2'd2;

   typedef struct packed {
      logic [COL_W-1:0]          col;
      logic signed [VALUE_W-1:0] value;
   } nz_entry_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctrl_type;

   typedef struct packed {
      logic busy;
      logic sat;
   } mac_stat_type;

endpackage

FILE: rtl/core/csm_ifs.sv
interface csm_req_if import csm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [ACTION_W-1:0]       action;
   logic signed [VALUE_W-1:0] elem_value;
   logic [VEC_AW-1:0]         vec_index;

   modport source (output valid, action, elem_value, vec_index, input ready);
   modport sink (input valid, action, elem_value, vec_index, output ready);
endinterface

interface csm_rsp_if import csm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [ROW_IDX_W-1:0]      row_index;
   logic signed [VALUE_W-1:0] result_value;
   logic                      last;
   logic [STATUS_W-1:0]       status;

   modport source (output valid, row_index, result_value, last, status, input ready);
   modport sink (input valid, row_index, result_value, last, status, output ready);
endinterface

FILE: rtl/core/csm_mac.sv
module csm_mac import csm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  mac_ctrl_type              ctrl,
   input  logic signed [VALUE_W-1:0] op_a,
   input  logic signed [VALUE_W-1:0] op_b,
   output logic signed [ACC_W-1:0]   acc,
   output mac_stat_type              stat
);

   logic signed [ACC_W-1:0] prod_ff;
   logic                    prod_vld_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic                    sat_ff;
   logic signed [ACC_W-1:0] prod_in;
   logic signed [ACC_W-1:0] sum;
   logic                    ovf;
   logic signed [ACC_W-1:0] acc_in;

   assign prod_in = op_a * op_b;
   assign sum     = acc_ff + prod_ff;
   assign ovf     = (acc_ff[ACC_W-1] == prod_ff[ACC_W-1]) && (sum[ACC_W-1] != acc_ff[ACC_W-1]);

   always_comb begin
      if (ovf) begin
         acc_in = acc_ff[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_in = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctrl.clear) begin
         acc_ff <= '0;
         sat_ff <= 1'b0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_in;
         sat_ff <= sat_ff | ovf;
      end
   end

   assign acc       = acc_ff;
   assign stat.busy = prod_vld_ff;
   assign stat.sat  = sat_ff;

endmodule

FILE: rtl/core/csr_sparse_matvec.sv
// Sparse matrix-vector multiply with compressed row storage.
// req_chan takes items: load the next matrix element (row-major), write one
// vector element by index, or compute all rows. rsp_chan returns results:
// one per row for a compute item (last set on the final row), and one
// flagged item (status ignored, last set) for a load beyond rows*cols or a
// kept element that finds the nonzero store full.
// csr_write/csr_index/csr_data set the row count, column count and drop
// threshold; a row or column write starts a new matrix.
// Loads and vector writes are taken back to back while rsp_chan is free; a flagged load
// shows its result on the next cycle.
// A compute item walks the stored nonzeros through a read-read-multiply-
// accumulate pipeline over the nonzero and vector memories: for each row it
// reads the row bounds, issues the nonzeros, drains, then writes the result.
// No item is taken while a compute runs.
// Reset restores default sizes, threshold, counters and state. Nonzero and
// row-start entries are read only after a write since the last restart.
// When rsp_chan stalls, the block holds its pending result and stops
// taking items until that result is taken.
`include "csr_sparse_matvec_defines.svh"

module csr_sparse_matvec import csm_pkg::*; #(
   parameter int ROWS_MAX = ROWS_MAX_DEF,
   parameter int COLS_MAX = COLS_MAX_DEF,
   parameter int NNZ_MAX  = NNZ_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   csm_req_if.sink               req_chan,
   csm_rsp_if.source             rsp_chan,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int RowCntW = $clog2(ROWS_MAX + 1);
   localparam int RowAW   = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
   localparam int NzCntW  = $clog2(NNZ_MAX + 1);
   localparam int NzAW    = (NNZ_MAX > 1) ? $clog2(NNZ_MAX) : 1;
   localparam int ColLim  = (COLS_MAX < VEC_DEPTH) ? COLS_MAX : VEC_DEPTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_RD,
      ST_ROW_END,
      ST_WALK,
      ST_DRAIN,
      ST_FINAL
   } state_type;

   function automatic logic [RowCntW-1:0] clamp_rows(input logic [CFG_DIM_W-1:0] v);
      logic [RowCntW-1:0] r;
      if (v == '0) begin
         r = RowCntW'(1);
      end else if (v > CFG_DIM_W'(ROWS_MAX)) begin
         r = RowCntW'(ROWS_MAX);
      end else begin
         r = RowCntW'(v);
      end
      return r;
   endfunction

   function automatic logic [CFG_DIM_W-1:0] clamp_cols(input logic [CFG_DIM_W-1:0] v);
      logic [CFG_DIM_W-1:0] c;
      if (v == '0) begin
         c = CFG_DIM_W'(1);
      end else if (v > CFG_DIM_W'(ColLim)) begin
         c = CFG_DIM_W'(ColLim);
      end else begin
         c = v;
      end
      return c;
   endfunction

   // configuration and load bookkeeping
   logic [RowCntW-1:0]   rows_ff;
   logic [CFG_DIM_W-1:0] cols_ff;
   logic [THR_W-1:0]     thr_ff;
   logic [RowCntW-1:0]   load_row_ff;
   logic [COL_W-1:0]     load_col_ff;
   logic [NzCntW-1:0]    nz_cnt_ff;

   // sequencer
   state_type            state_ff;
   logic [RowCntW-1:0]   row_ff;
   logic [NzCntW-1:0]    k_ff;
   logic [NzCntW-1:0]    end_ff;
   logic                 rd1_vld_ff;
   logic                 rd2_vld_ff;

   // memories and read registers
   nz_entry_type              nz_mem [NNZ_MAX];
   logic [NzCntW-1:0]         start_mem [ROWS_MAX];
   logic signed [VALUE_W-1:0] vec_mem [VEC_DEPTH];
   nz_entry_type              nz_rdata_ff;
   logic [NzCntW-1:0]         start_rdata_ff;
   logic signed [VALUE_W-1:0] vec_rdata_ff;
   logic signed [VALUE_W-1:0] val2_ff;

   // result register
   logic                      rsp_valid_ff;
   logic [ROW_IDX_W-1:0]      rsp_row_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_last_ff;
   status_type                rsp_status_ff;

   logic                      req_fire;
   logic                      rsp_free;
   logic [VALUE_W-1:0]        mag;
   logic                      keep;
   logic                      nz_full;
   logic                      load_full;
   logic                      load_step;
   logic                      load_flag;
   logic                      col_wrap;
   logic                      nz_we;
   logic                      start_we;
   logic                      vec_we;
   logic [RowCntW-1:0]        started;
   logic [RowCntW-1:0]        row_next;
   logic [NzCntW-1:0]         row_end;
   logic                      row_last;
   logic                      walk_issue;
   logic                      drained;
   mac_ctrl_type              mac_ctrl;
   mac_stat_type              mac_stat;
   logic signed [ACC_W-1:0]   acc;
   logic                      fits;
   logic signed [VALUE_W-1:0] final_value;
   status_type                final_status;

   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign mag       = req_chan.elem_value[VALUE_W-1] ?
                      (VALUE_W'(0) - $unsigned(req_chan.elem_value)) :
                      $unsigned(req_chan.elem_value);
   assign keep      = mag > {1'b0, thr_ff};
   assign nz_full   = nz_cnt_ff == NzCntW'(NNZ_MAX);
   assign load_full = load_row_ff == rows_ff;
   assign load_step = req_fire && (req_chan.action == ACT_LOAD) && !load_full;
   assign load_flag = req_fire && (req_chan.action == ACT_LOAD) &&
                      (load_full || (keep && nz_full));
   assign col_wrap  = (CFG_DIM_W'(load_col_ff) + CFG_DIM_W'(1)) == cols_ff;
   assign nz_we     = load_step && keep && !nz_full;
   assign start_we  = load_step && (load_col_ff == '0);
   assign vec_we    = req_fire && (req_chan.action == ACT_VEC);

   assign started  = load_row_ff + RowCntW'(load_col_ff != '0);
   assign row_next = row_ff + RowCntW'(1);
   assign row_last = row_next == rows_ff;

   always_comb begin
      if (row_ff < started) begin
         row_end = (row_next < started) ? start_rdata_ff : nz_cnt_ff;
      end else begin
         row_end = k_ff;
      end
   end

   assign walk_issue = (state_ff == ST_WALK) && (k_ff < end_ff);
   assign drained    = !rd1_vld_ff && !rd2_vld_ff && !mac_stat.busy;

   assign mac_ctrl.clear = state_ff == ST_ROW_RD;
   assign mac_ctrl.valid = rd2_vld_ff;

   csm_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .op_a  (val2_ff),
      .op_b  (vec_rdata_ff),
      .acc   (acc),
      .stat  (mac_stat)
   );

   // floor shift by 16, then saturate to 32 bits
   assign fits = acc[ACC_W-1:47] == {(ACC_W-47){acc[ACC_W-1]}};

   always_comb begin
      if (fits) begin
         final_value = acc[47:16];
      end else if (acc[ACC_W-1]) begin
         final_value = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         final_value = {1'b0, {(VALUE_W-1){1'b1}}};
      end
      final_status = (mac_stat.sat || !fits) ? STAT_SAT : STAT_OK;
   end

   always_ff @(posedge clock) begin
      if (nz_we) begin
         nz_mem[nz_cnt_ff[NzAW-1:0]] <= '{col: load_col_ff, value: req_chan.elem_value};
      end
      nz_rdata_ff <= nz_mem[k_ff[NzAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (start_we) begin
         start_mem[load_row_ff[RowAW-1:0]] <= nz_cnt_ff;
      end
      start_rdata_ff <= start_mem[row_next[RowAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_mem[req_chan.vec_index] <= req_chan.elem_value;
      end
      vec_rdata_ff <= vec_mem[nz_rdata_ff.col];
      val2_ff      <= nz_rdata_ff.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff     <= RowCntW'(ROWS_MAX);
         cols_ff     <= CFG_DIM_W'(ColLim);
         thr_ff      <= '0;
         load_row_ff <= '0;
         load_col_ff <= '0;
         nz_cnt_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_NUM_ROWS: begin
               rows_ff     <= clamp_rows(csr_data[CFG_DIM_W-1:0]);
               load_row_ff <= '0;
               load_col_ff <= '0;
               nz_cnt_ff   <= '0;
            end
            CSR_NUM_COLS: begin
               cols_ff     <= clamp_cols(csr_data[CFG_DIM_W-1:0]);
               load_row_ff <= '0;
               load_col_ff <= '0;
               nz_cnt_ff   <= '0;
            end
            CSR_THRESHOLD: begin
               thr_ff <= csr_data[THR_W-1:0];
            end
            default: begin
            end
         endcase
      end else if (load_step) begin
         if (col_wrap) begin
            load_col_ff <= '0;
            load_row_ff <= load_row_ff + RowCntW'(1);
         end else begin
            load_col_ff <= load_col_ff + COL_W'(1);
         end
         if (nz_we) begin
            nz_cnt_ff <= nz_cnt_ff + NzCntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd1_vld_ff   <= 1'b0;
         rd2_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd1_vld_ff <= walk_issue;
         rd2_vld_ff <= rd1_vld_ff;
         if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_chan.action == ACT_COMPUTE)) begin
                  row_ff   <= '0;
                  k_ff     <= '0;
                  state_ff <= ST_ROW_RD;
               end
               if (load_flag) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_row_ff    <= '0;
                  rsp_value_ff  <= '0;
                  rsp_last_ff   <= 1'b1;
                  rsp_status_ff <= STAT_IGNORED;
               end
            end
            ST_ROW_RD: begin
               state_ff <= ST_ROW_END;
            end
            ST_ROW_END: begin
               end_ff   <= row_end;
               state_ff <= ST_WALK;
            end
            ST_WALK: begin
               if (walk_issue) begin
                  k_ff <= k_ff + NzCntW'(1);
               end else begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (drained) begin
                  state_ff <= ST_FINAL;
               end
            end
            ST_FINAL: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_row_ff    <= ROW_IDX_W'(row_ff);
                  rsp_value_ff  <= final_value;
                  rsp_last_ff   <= row_last;
                  rsp_status_ff <= final_status;
                  if (row_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     row_ff   <= row_next;
                     state_ff <= ST_ROW_RD;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.row_index    = rsp_row_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.last         = rsp_last_ff;
   assign rsp_chan.status       = rsp_status_ff;

   `CSM_ASSERT_IMPLIES(a_nz_bound, 1'b1, nz_cnt_ff <= NzCntW'(NNZ_MAX))
   `CSM_ASSERT_IMPLIES(a_load_row_bound, 1'b1, load_row_ff <= rows_ff)
   `CSM_ASSERT_IMPLIES(a_final_drained, state_ff == ST_FINAL, drained)
   `CSM_ASSERT_NEXT(a_last_ends_run, (state_ff == ST_FINAL) && rsp_free && row_last, (state_ff == ST_IDLE) && rsp_chan.valid && rsp_chan.last)

endmodule
